[rtl/emh_pkg.sv]
package emh_pkg;

    localparam int unsigned LANES       = 8;
    localparam int unsigned LANE_W      = $clog2(LANES);
    localparam logic [31:0] BLOCK_BYTES = 32'd32;
    localparam logic [31:0] MIX_ADD     = 32'h3B11_A33C;
    localparam logic [31:0] FIN_MUL1    = 32'hC2AD_39BB;
    localparam logic [31:0] FIN_MUL2    = 32'hE037_A692;

    localparam logic [31:0] PRE_MUL [LANES] = '{
        32'hB19C_E1AA, 32'hB33F_1B01, 32'h4093_AEE0, 32'hC903_1C00,
        32'h1FCC_49A2, 32'h4DC3_3A4D, 32'hBE62_14AE, 32'hA329_EB99
    };
    localparam logic [31:0] POST_MUL [LANES] = '{
        32'hDE33_BB89, 32'hA39B_1CE1, 32'h1E91_9393, 32'h91BB_3DDD,
        32'h82A0_3CCE, 32'h55FE_C879, 32'h4A99_D300, 32'hC305_9BF0
    };

    typedef enum logic [1:0] {
        MUL_PRE  = 2'd0,
        MUL_POST = 2'd1,
        MUL_FIN1 = 2'd2,
        MUL_FIN2 = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    en;
        mul_op_t op;
    } mul_ctl_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL1 = 8'b0000_0010,
        ST_MUL2 = 8'b0000_0100,
        ST_MIX  = 8'b0000_1000,
        ST_FIN1 = 8'b0001_0000,
        ST_FIN2 = 8'b0010_0000,
        ST_FIN3 = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

endpackage

[rtl/eight_lane_murmur_hash32_top.sv]
// A word that is not last goes through the pre-multiply, post-multiply and lane mix states,
// and the block is not ready for another word until the lane mix is done.
// A last word adds the same steps for each zero pad word up to the block end, then the
// finalization of each of the 8 lanes, then a load of the output register once it is free.
// All multiplies go through one shared 32x32 multiplier.
// Reset (aresetn, synchronous) clears the seed, sequencer and output valid.
module eight_lane_murmur_hash32_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);
    import emh_pkg::*;

    state_t              state_reg, state_next;
    logic [31:0]         seed_reg;
    logic [31:0]         lane_reg [LANES];
    logic [LANE_W-1:0]   ptr_reg, ptr_next;
    logic [31:0]         count_reg, count_next;
    logic                in_msg_reg, in_msg_next;
    logic [31:0]         word_reg, word_next;
    logic                last_reg, last_next;
    logic [31:0]         acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_hash_reg;

    logic                accept;
    logic                load_seed;
    logic                lane_we;
    logic [31:0]         lane_wdata;
    logic [31:0]         lane_rd;
    logic [31:0]         mix_x;
    logic [31:0]         byte_mask;
    logic                out_load;
    logic [LANE_W-1:0]   ptr_inc;
    mul_ctl_t            mul_ctl;
    logic [31:0]         mul_operand;
    logic [31:0]         product;

    emh_mul_unit u_mul (
        .aclk    (aclk),
        .ctl     (mul_ctl),
        .lane    (ptr_reg),
        .operand (mul_operand),
        .product (product)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign lane_rd      = lane_reg[ptr_reg];
    assign ptr_inc      = ptr_reg + 1'b1;
    assign mix_x        = {(lane_rd ^ product) << 13} | ((lane_rd ^ product) >> 19);
    assign lane_wdata   = mix_x + {mix_x[29:0], 2'b00} + MIX_ADD;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    always_comb begin
        unique case (s_valid_bytes)
            3'd1:    byte_mask = 32'h0000_00FF;
            3'd2:    byte_mask = 32'h0000_FFFF;
            3'd3:    byte_mask = 32'h00FF_FFFF;
            default: byte_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        in_msg_next  = in_msg_reg;
        word_next    = word_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        load_seed    = 1'b0;
        lane_we      = 1'b0;
        out_load     = 1'b0;
        mul_ctl.en   = 1'b0;
        mul_ctl.op   = MUL_PRE;
        mul_operand  = word_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    word_next = s_data_word & byte_mask;
                    last_next = s_last_word;
                    acc_next  = '0;
                    if (!in_msg_reg) begin
                        load_seed  = 1'b1;
                        ptr_next   = '0;
                        count_next = '0;
                    end
                    if (s_valid_bytes != 3'd0) begin
                        in_msg_next = 1'b1;
                        state_next  = ST_MUL1;
                    end else if (s_last_word) begin
                        if (!in_msg_reg || ptr_reg == '0) begin
                            state_next = ST_FIN1;
                        end else begin
                            word_next  = '0;
                            state_next = ST_MUL1;
                        end
                    end
                end
            end
            ST_MUL1: begin
                mul_ctl.en = 1'b1;
                mul_ctl.op = MUL_PRE;
                if (ptr_reg == '0) begin
                    count_next = count_reg + BLOCK_BYTES;
                end
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.op  = MUL_POST;
                mul_operand = product;
                state_next  = ST_MIX;
            end
            ST_MIX: begin
                lane_we  = 1'b1;
                ptr_next = ptr_inc;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (ptr_inc == '0) begin
                    state_next = ST_FIN1;
                end else begin
                    word_next  = '0;
                    state_next = ST_MUL1;
                end
            end
            ST_FIN1: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.op  = MUL_FIN1;
                mul_operand = lane_rd ^ count_reg;
                state_next  = ST_FIN2;
            end
            ST_FIN2: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.op  = MUL_FIN2;
                mul_operand = product;
                state_next  = ST_FIN3;
            end
            ST_FIN3: begin
                acc_next = acc_reg ^ product ^ (product >> 16);
                ptr_next = ptr_inc;
                if (ptr_inc == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_FIN1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    in_msg_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= '0;
            ptr_reg     <= '0;
            count_reg   <= '0;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        if (out_load) begin
            m_hash_reg <= acc_reg;
        end
        if (load_seed) begin
            for (int i = 0; i < LANES; i++) begin
                lane_reg[i] <= seed_reg;
            end
        end else if (lane_we) begin
            lane_reg[ptr_reg] <= lane_wdata;
        end
    end

endmodule

[rtl/emh_mul_unit.sv]
module emh_mul_unit (
    input  logic                         aclk,
    input  emh_pkg::mul_ctl_t            ctl,
    input  logic [emh_pkg::LANE_W-1:0]   lane,
    input  logic [31:0]                  operand,
    output logic [31:0]                  product
);
    import emh_pkg::*;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] product_reg;
    logic [31:0] product_next;

    // operand pre-transform per op, then low 32 bits of the product
    always_comb begin
        unique case (ctl.op)
            MUL_PRE: begin
                op_a = operand;
                op_b = PRE_MUL[lane];
            end
            MUL_POST: begin
                op_a = {operand[16:0], operand[31:17]};
                op_b = POST_MUL[lane];
            end
            MUL_FIN1: begin
                op_a = operand ^ (operand >> 16);
                op_b = FIN_MUL1;
            end
            MUL_FIN2: begin
                op_a = operand ^ (operand >> 13);
                op_b = FIN_MUL2;
            end
        endcase
        product_next = op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule
